[rtl/pfc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types, constants and small table functions for the 5x5 digraph
// cipher: operation codes, queue command format, square geometry helpers.
// ----------------------------------------------------------------------------
package pfc_pkg;

    localparam int LETTER_W    = 5;
    localparam int OP_W        = 3;
    localparam int SIDE        = 5;
    localparam int CELLS       = SIDE * SIDE;
    localparam int LETTERS     = 26;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [LETTER_W-1:0] CODE_I = 5'd8;
    localparam logic [LETTER_W-1:0] CODE_J = 5'd9;
    localparam logic [LETTER_W-1:0] CODE_X = 5'd23;

    typedef enum logic [OP_W-1:0] {
        OP_KEY     = 3'd0,
        OP_END_KEY = 3'd1,
        OP_ENCRYPT = 3'd2,
        OP_DECRYPT = 3'd3,
        OP_END_MSG = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        CMD_KEY,
        CMD_FILL,
        CMD_PAIR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [LETTER_W-1:0]   a;
        logic [LETTER_W-1:0]   b;
        logic                  decrypt;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_FILL,
        BK_POS,
        BK_SQ,
        BK_OUT0,
        BK_OUT1
    } back_state_t;

    // n-th letter of the 25-letter alphabet (J left out)
    function automatic logic [LETTER_W-1:0] alpha_code(input logic [LETTER_W-1:0] idx);
        alpha_code = (idx < CODE_J) ? idx : idx + 5'd1;
    endfunction

    function automatic logic [2:0] row_of(input logic [LETTER_W-1:0] pos);
        priority if (pos >= 5'd20) row_of = 3'd4;
        else if (pos >= 5'd15)     row_of = 3'd3;
        else if (pos >= 5'd10)     row_of = 3'd2;
        else if (pos >= 5'd5)      row_of = 3'd1;
        else                       row_of = 3'd0;
    endfunction

    function automatic logic [2:0] col_of(input logic [LETTER_W-1:0] pos);
        logic [2:0]          r;
        logic [LETTER_W-1:0] base;
        r      = row_of(pos);
        base   = {r, 2'b00} + {2'b00, r};
        col_of = 3'(pos - base);
    endfunction

    // +1 mod 5 to encipher, -1 mod 5 to decipher
    function automatic logic [2:0] step5(input logic [2:0] v, input logic dec);
        if (dec) step5 = (v == 3'd0) ? 3'd4 : v - 3'd1;
        else     step5 = (v == 3'd4) ? 3'd0 : v + 3'd1;
    endfunction

    function automatic logic [LETTER_W-1:0] cell_of(input logic [2:0] r, input logic [2:0] c);
        cell_of = {r, 2'b00} + {2'b00, r} + {2'b00, c};
    endfunction

endpackage

[rtl/playfair_digraph_cipher_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_top
// 5x5 digraph cipher: key square build, pair encipher and decipher.
//
//   channel   ports                          beat contents
//   input     s_valid s_ready                s_operation, s_letter
//   result    m_valid m_ready                m_out_letter, m_last
//
// Front section takes one input beat per cycle while the command queue
// (QUEUE_DEPTH entries) has room. The back section places a key letter as
// it is popped, fills the square from the 25-letter alphabet on end of key,
// and runs position and square RAM lookups plus two result beats on a pair.
// Reset (aresetn low, synchronous) empties the square and drops a held letter.
// A stalled result beat holds the back section; the queue keeps filling.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher_top
    import pfc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [OP_W-1:0]     s_operation,
    input  logic [LETTER_W-1:0] s_letter,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [LETTER_W-1:0] m_out_letter,
    output logic                m_last
);

    logic push, q_full, q_pop, q_valid;
    cmd_t push_cmd, q_head;

    pfc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_letter    (s_letter),
        .q_full      (q_full),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    pfc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    pfc_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_letter (m_out_letter),
        .m_last       (m_last)
    );

endmodule

[rtl/pfc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module pfc_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 25,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a <= mem_reg[raddr_a];
        rdata_b <= mem_reg[raddr_b];
    end

endmodule

[rtl/pfc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_front
// Accepts input beats, folds J into I, drops malformed items and forms
// letter pairs (with X filler) before handing commands to the queue.
// ----------------------------------------------------------------------------
module pfc_front
    import pfc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [OP_W-1:0]     s_operation,
    input  logic [LETTER_W-1:0] s_letter,
    input  logic                q_full,
    output logic                push,
    output cmd_t                push_cmd
);

    logic [LETTER_W-1:0] held_letter_reg, held_letter_next;
    logic                held_valid_reg,  held_valid_next;
    logic [LETTER_W-1:0] code;
    logic                code_ok;
    logic                accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign code    = (s_letter == CODE_J) ? CODE_I : s_letter;
    assign code_ok = code < LETTER_W'(LETTERS);

    always_comb begin
        held_letter_next = held_letter_reg;
        held_valid_next  = held_valid_reg;
        push             = 1'b0;
        push_cmd.kind    = CMD_PAIR;
        push_cmd.a       = held_letter_reg;
        push_cmd.b       = code;
        push_cmd.decrypt = 1'b0;
        if (accept) begin
            unique case (op_t'(s_operation))
                OP_KEY: begin
                    push          = code_ok;
                    push_cmd.kind = CMD_KEY;
                    push_cmd.a    = code;
                end
                OP_END_KEY: begin
                    push          = 1'b1;
                    push_cmd.kind = CMD_FILL;
                end
                OP_ENCRYPT: begin
                    if (code_ok) begin
                        if (!held_valid_reg) begin
                            held_letter_next = code;
                            held_valid_next  = 1'b1;
                        end else if (held_letter_reg == code) begin
                            // doubled letter: pad with X, keep the new one pending
                            push       = 1'b1;
                            push_cmd.b = CODE_X;
                        end else begin
                            push            = 1'b1;
                            held_valid_next = 1'b0;
                        end
                    end
                end
                OP_DECRYPT: begin
                    if (code_ok) begin
                        if (!held_valid_reg) begin
                            held_letter_next = code;
                            held_valid_next  = 1'b1;
                        end else begin
                            push             = 1'b1;
                            push_cmd.decrypt = 1'b1;
                            held_valid_next  = 1'b0;
                        end
                    end
                end
                OP_END_MSG: begin
                    if (held_valid_reg) begin
                        push            = 1'b1;
                        push_cmd.b      = CODE_X;
                        held_valid_next = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_letter_reg <= '0;
            held_valid_reg  <= 1'b0;
        end else begin
            held_letter_reg <= held_letter_next;
            held_valid_reg  <= held_valid_next;
        end
    end

endmodule

[rtl/pfc_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_queue
// Small command FIFO between the front and back sections.
// ----------------------------------------------------------------------------
module pfc_queue
    import pfc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t head
);

    cmd_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;
    logic          do_push, do_pop;

    assign full      = count_reg == CW'(DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/pfc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_back
// Executes queued commands: builds the key square, completes it with the
// unused alphabet, and enciphers or deciphers letter pairs.
// ----------------------------------------------------------------------------
module pfc_back
    import pfc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  cmd_t                q_head,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [LETTER_W-1:0] m_out_letter,
    output logic                m_last
);

    back_state_t state_reg, state_next;

    logic [LETTERS-1:0]  used_reg,      used_next;
    logic [LETTER_W-1:0] fill_count_reg, fill_count_next;
    logic [LETTER_W-1:0] fill_idx_reg,  fill_idx_next;
    logic                used_a_reg, used_b_reg;
    logic                dec_reg;
    logic                oa_ok_reg, ob_ok_reg;
    logic [LETTER_W-1:0] out_a_reg, out_b_reg;

    logic                place_en, do_place;
    logic [LETTER_W-1:0] place_code;
    logic [LETTER_W-1:0] pos_rd_a, pos_rd_b;
    logic [LETTER_W-1:0] sq_rd_a, sq_rd_b;
    logic [LETTER_W-1:0] pa, pb, oa, ob;
    logic [2:0]          ra, ca, rb, cb;

    // ---- next state ----
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    unique case (q_head.kind)
                        CMD_FILL: state_next = BK_FILL;
                        CMD_PAIR: state_next = BK_POS;
                        default:  state_next = BK_IDLE;
                    endcase
                end
            end
            BK_FILL: if (fill_idx_reg == LETTER_W'(CELLS - 1)) state_next = BK_IDLE;
            BK_POS:  state_next = BK_SQ;
            BK_SQ:   state_next = BK_OUT0;
            BK_OUT0: if (m_ready) state_next = BK_OUT1;
            BK_OUT1: if (m_ready) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    // ---- outputs ----
    always_comb begin
        q_pop        = (state_reg == BK_IDLE) && q_valid;
        m_valid      = (state_reg == BK_OUT0) || (state_reg == BK_OUT1);
        m_last       = state_reg == BK_OUT1;
        m_out_letter = (state_reg == BK_OUT1) ? out_b_reg : out_a_reg;
        place_en     = (state_reg == BK_FILL) ||
                       (q_pop && q_head.kind == CMD_KEY);
        place_code   = (state_reg == BK_FILL) ? alpha_code(fill_idx_reg) : q_head.a;
    end

    assign do_place = place_en && (fill_count_reg < LETTER_W'(CELLS)) &&
                      !used_reg[place_code];

    always_comb begin
        fill_count_next = fill_count_reg + LETTER_W'(do_place);
        fill_idx_next   = (state_reg == BK_FILL) ? fill_idx_reg + LETTER_W'(1) : '0;
        for (int i = 0; i < LETTERS; i++) begin
            used_next[i] = used_reg[i] || (do_place && place_code == LETTER_W'(i));
        end
    end

    // ---- pair geometry (letters never placed sit at cell 0) ----
    always_comb begin
        pa = used_a_reg ? pos_rd_a : '0;
        pb = used_b_reg ? pos_rd_b : '0;
        ra = row_of(pa);
        ca = col_of(pa);
        rb = row_of(pb);
        cb = col_of(pb);
        if (ra == rb) begin
            oa = cell_of(ra, step5(ca, dec_reg));
            ob = cell_of(rb, step5(cb, dec_reg));
        end else if (ca == cb) begin
            oa = cell_of(step5(ra, dec_reg), ca);
            ob = cell_of(step5(rb, dec_reg), cb);
        end else begin
            oa = cell_of(ra, cb);
            ob = cell_of(rb, ca);
        end
    end

    pfc_ram #(.WIDTH(LETTER_W), .DEPTH(LETTERS)) u_pos_ram (
        .aclk    (aclk),
        .we      (do_place),
        .waddr   (place_code),
        .wdata   (fill_count_reg),
        .raddr_a (q_head.a),
        .raddr_b (q_head.b),
        .rdata_a (pos_rd_a),
        .rdata_b (pos_rd_b)
    );

    pfc_ram #(.WIDTH(LETTER_W), .DEPTH(CELLS)) u_square_ram (
        .aclk    (aclk),
        .we      (do_place),
        .waddr   (fill_count_reg),
        .wdata   (place_code),
        .raddr_a (oa),
        .raddr_b (ob),
        .rdata_a (sq_rd_a),
        .rdata_b (sq_rd_b)
    );

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            used_a_reg <= used_reg[q_head.a];
            used_b_reg <= used_reg[q_head.b];
            dec_reg    <= q_head.decrypt;
        end
        if (state_reg == BK_POS) begin
            // cells past the fill point read as A
            oa_ok_reg <= oa < fill_count_reg;
            ob_ok_reg <= ob < fill_count_reg;
        end
        if (state_reg == BK_SQ) begin
            out_a_reg <= oa_ok_reg ? sq_rd_a : '0;
            out_b_reg <= ob_ok_reg ? sq_rd_b : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= BK_IDLE;
            used_reg       <= '0;
            fill_count_reg <= '0;
            fill_idx_reg   <= '0;
        end else begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            fill_count_reg <= fill_count_next;
            fill_idx_reg   <= fill_idx_next;
        end
    end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 5x5 digraph cipher. A short directed sequence
// builds the key square and hits the corner cases: text before the square is
// complete, duplicate and J key letters, reserved opcodes, doubled X, mixed
// pairs and end-of-message padding. Random messages with random idles on both
// channels follow. Each accepted input beat updates an in-bench model of the
// square and held letter, and every result beat is checked against it in order.
// ----------------------------------------------------------------------------
module testbench
    import pfc_pkg::*;
();

    localparam int unsigned RANDOM_TEXT_ITEMS = 1800;
    localparam int unsigned HOLD_OFF_AFTER    = 300;
    localparam int unsigned HOLD_OFF_CYCLES   = 400;
    localparam int unsigned DRAIN_CYCLES      = 40;
    localparam int unsigned WATCHDOG_LIMIT    = 3000;

    localparam logic [OP_W-1:0]     OP_RESERVED_LO = 3'd5;
    localparam logic [OP_W-1:0]     OP_RESERVED_HI = 3'd7;
    localparam logic [LETTER_W-1:0] CODE_Z         = 5'd25;
    localparam logic [LETTER_W-1:0] CODE_TOP       = {LETTER_W{1'b1}};

    typedef struct {
        logic [OP_W-1:0]     op;
        logic [LETTER_W-1:0] letter;
    } cipher_req_t;

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                last;
    } cipher_beat_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [OP_W-1:0]     s_operation = '0;
    logic [LETTER_W-1:0] s_letter = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [LETTER_W-1:0] m_out_letter;
    logic                m_last;

    always #4 aclk = ~aclk;

    playfair_digraph_cipher_top DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_letter     (s_letter),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_letter (m_out_letter),
        .m_last       (m_last)
    );

    cipher_req_t  letters_to_send[$];
    cipher_beat_t cipher_letters_due[$];

    // model of the block's key square and pairing state
    logic [LETTER_W-1:0] key_square[CELLS];
    logic [LETTER_W-1:0] key_pos[LETTERS];
    bit                  key_used[LETTERS];
    int unsigned         key_fill;
    logic [LETTER_W-1:0] pend_letter;
    bit                  pend_valid;

    int unsigned fail_count;
    int unsigned beats_in;
    int unsigned beats_checked;
    int unsigned enc_pairs;
    int unsigned dec_pairs;
    int unsigned doubled_pairs;
    int unsigned padded_pairs;

    int unsigned tx_gap, tx_calm, rx_stall, rx_calm, idle_cycles;
    bit          hold_off_done;
    logic        holding_off = 1'b0;
    cipher_req_t tx_item;

    function automatic int unsigned pause_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void place_key_letter(logic [LETTER_W-1:0] code);
        if (code >= LETTERS || key_fill >= CELLS || key_used[code]) return;
        key_square[key_fill] = code;
        key_pos[code]        = LETTER_W'(key_fill);
        key_used[code]       = 1'b1;
        key_fill++;
    endfunction

    function automatic void push_pair(logic [LETTER_W-1:0] a, logic [LETTER_W-1:0] b,
                                      bit dec);
        int unsigned pa, pb, ra, ca, rb, cb, oa, ob, sh;
        sh = dec ? SIDE - 1 : 1;
        pa = key_pos[a] % CELLS;
        pb = key_pos[b] % CELLS;
        ra = pa / SIDE;
        ca = pa % SIDE;
        rb = pb / SIDE;
        cb = pb % SIDE;
        if (ra == rb) begin
            oa = ra * SIDE + (ca + sh) % SIDE;
            ob = rb * SIDE + (cb + sh) % SIDE;
        end else if (ca == cb) begin
            oa = ((ra + sh) % SIDE) * SIDE + ca;
            ob = ((rb + sh) % SIDE) * SIDE + cb;
        end else begin
            oa = ra * SIDE + cb;
            ob = rb * SIDE + ca;
        end
        cipher_letters_due.push_back({key_square[oa], 1'b0});
        cipher_letters_due.push_back({key_square[ob], 1'b1});
        if (dec) dec_pairs++;
        else     enc_pairs++;
    endfunction

    function automatic void predict_cipher(logic [OP_W-1:0] op, logic [LETTER_W-1:0] letter);
        logic [LETTER_W-1:0] code;
        int unsigned         c;
        code = (letter == CODE_J) ? CODE_I : letter;
        case (op)
            OP_KEY: begin
                if (code < LETTERS) place_key_letter(code);
            end
            OP_END_KEY: begin
                for (c = 0; c < LETTERS; c++)
                    if (c != CODE_J) place_key_letter(LETTER_W'(c));
            end
            OP_ENCRYPT: begin
                if (code < LETTERS) begin
                    if (!pend_valid) begin
                        pend_letter = code;
                        pend_valid  = 1'b1;
                    end else if (pend_letter == code) begin
                        // doubled letter: X goes in between, new letter stays held
                        push_pair(pend_letter, CODE_X, 1'b0);
                        doubled_pairs++;
                    end else begin
                        pend_valid = 1'b0;
                        push_pair(pend_letter, code, 1'b0);
                    end
                end
            end
            OP_DECRYPT: begin
                if (code < LETTERS) begin
                    if (!pend_valid) begin
                        pend_letter = code;
                        pend_valid  = 1'b1;
                    end else begin
                        pend_valid = 1'b0;
                        push_pair(pend_letter, code, 1'b1);
                    end
                end
            end
            OP_END_MSG: begin
                // held letter is padded with X and always enciphered
                if (pend_valid) begin
                    pend_valid = 1'b0;
                    push_pair(pend_letter, CODE_X, 1'b0);
                    padded_pairs++;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void queue_letter(logic [OP_W-1:0] op, logic [LETTER_W-1:0] letter);
        letters_to_send.push_back('{op, letter});
    endfunction

    function automatic logic [LETTER_W-1:0] ch(byte c);
        return LETTER_W'(c - "A");
    endfunction

    function automatic logic [LETTER_W-1:0] text_letter();
        if ($urandom_range(0, 11) == 0) return CODE_X;
        return LETTER_W'($urandom_range(0, LETTERS - 1));
    endfunction

    function automatic void queue_directed();
        queue_letter(OP_ENCRYPT, ch("H"));       // square still empty
        queue_letter(OP_ENCRYPT, ch("E"));
        queue_letter(OP_KEY, ch("P"));
        queue_letter(OP_KEY, CODE_J);
        queue_letter(OP_KEY, ch("A"));
        queue_letter(OP_ENCRYPT, CODE_Z);        // held across key beats
        queue_letter(OP_KEY, CODE_X);
        queue_letter(OP_KEY, CODE_I);            // already placed as J
        queue_letter(OP_KEY, CODE_TOP);
        queue_letter(OP_RESERVED_LO, ch("A"));
        queue_letter(OP_DECRYPT, ch("A"));       // mixed pair, partial square
        queue_letter(OP_RESERVED_HI, CODE_TOP);
        queue_letter(OP_END_KEY, ch("A"));
        queue_letter(OP_END_KEY, CODE_TOP);
        queue_letter(OP_KEY, ch("B"));           // square full
        queue_letter(OP_ENCRYPT, CODE_X);
        queue_letter(OP_ENCRYPT, CODE_X);
        queue_letter(OP_ENCRYPT, CODE_TOP);
        queue_letter(OP_END_MSG, ch("A"));
        queue_letter(OP_DECRYPT, CODE_J);
        queue_letter(OP_END_MSG, CODE_Z);
        queue_letter(OP_END_MSG, ch("A"));
        queue_letter(OP_ENCRYPT, ch("A"));
        queue_letter(OP_ENCRYPT, CODE_Z);
        queue_letter(OP_DECRYPT, LETTER_W'(LETTERS));
    endfunction

    function automatic void queue_random();
        int unsigned         text_items, len, n;
        bit                  dec;
        logic [LETTER_W-1:0] prev, ltr;
        text_items = 0;
        while (text_items < RANDOM_TEXT_ITEMS) begin
            if ($urandom_range(0, 99) < 85) begin
                dec  = 1'($urandom_range(0, 1));
                len  = $urandom_range(1, 14);
                prev = text_letter();
                for (n = 0; n < len; n++) begin
                    ltr = ($urandom_range(0, 4) == 0) ? prev : text_letter();
                    queue_letter(dec ? OP_DECRYPT : OP_ENCRYPT, ltr);
                    prev = ltr;
                end
                text_items += len;
                if ($urandom_range(0, 5) != 0) begin
                    queue_letter(OP_END_MSG, LETTER_W'($urandom_range(0, CODE_TOP)));
                    text_items++;
                end
            end else begin
                case ($urandom_range(0, 5))
                    0: queue_letter(OP_KEY, LETTER_W'($urandom_range(0, CODE_TOP)));
                    1: queue_letter(OP_END_KEY, LETTER_W'($urandom_range(0, CODE_TOP)));
                    2: queue_letter(OP_W'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI)),
                                    LETTER_W'($urandom_range(0, CODE_TOP)));
                    3: queue_letter($urandom_range(0, 1) ? OP_ENCRYPT : OP_DECRYPT,
                                    LETTER_W'($urandom_range(LETTERS, CODE_TOP)));
                    4: begin
                        // lone letter of either mode, pairs up with whatever is held
                        queue_letter($urandom_range(0, 1) ? OP_ENCRYPT : OP_DECRYPT,
                                     text_letter());
                        text_items++;
                    end
                    default: begin
                        queue_letter(OP_END_MSG, LETTER_W'($urandom_range(0, CODE_TOP)));
                        text_items++;
                    end
                endcase
            end
        end
    endfunction

    task automatic check_beat(logic [LETTER_W-1:0] ltr, logic lst);
        cipher_beat_t want;
        if (cipher_letters_due.size() == 0) begin
            $error("result beat with nothing expected: out_letter %0d last %0d", ltr, lst);
            fail_count++;
        end else begin
            want = cipher_letters_due.pop_front();
            if (want.letter !== ltr) begin
                $error("out_letter: expected %0d, actual %0d", want.letter, ltr);
                fail_count++;
            end
            if (want.last !== lst) begin
                $error("last: expected %0d, actual %0d", want.last, lst);
                fail_count++;
            end
        end
        beats_checked++;
    endtask

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap  = 0;
            tx_calm = 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_cipher(s_operation, s_letter);
                beats_in++;
            end
            if (!s_valid || s_ready) begin
                if (tx_calm != 0) tx_calm--;
                else if ($urandom_range(0, 99) == 0) tx_calm = $urandom_range(30, 120);
                if (tx_gap != 0) begin
                    tx_gap--;
                    s_valid <= 1'b0;
                end else if (letters_to_send.size() != 0) begin
                    tx_item = letters_to_send.pop_front();
                    s_operation <= tx_item.op;
                    s_letter    <= tx_item.letter;
                    s_valid     <= 1'b1;
                    // keep pushing while the result side is held off
                    tx_gap = (tx_calm != 0 || holding_off) ? 0 : pause_len();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and ready generator
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready     <= 1'b0;
            holding_off <= 1'b0;
            rx_stall    = 0;
            rx_calm     = 0;
        end else begin
            if (m_valid && m_ready) check_beat(m_out_letter, m_last);
            if (rx_calm != 0) rx_calm--;
            else if ($urandom_range(0, 99) == 0) rx_calm = $urandom_range(30, 120);
            if (!hold_off_done && beats_checked >= HOLD_OFF_AFTER) begin
                hold_off_done = 1'b1;
                rx_stall      = HOLD_OFF_CYCLES;
            end else if (rx_stall == 0 && rx_calm == 0 && $urandom_range(0, 3) == 0) begin
                rx_stall = pause_len();
            end
            if (rx_stall != 0) begin
                rx_stall--;
                m_ready     <= 1'b0;
                holding_off <= (rx_stall > HOLD_OFF_CYCLES / 2);
            end else begin
                m_ready     <= 1'b1;
                holding_off <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
                         WATCHDOG_LIMIT, cipher_letters_due.size());
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    initial begin
        // after reset every letter sits at cell 0 and every cell holds A
        foreach (key_square[i]) key_square[i] = '0;
        foreach (key_pos[i]) key_pos[i] = '0;
        queue_directed();
        queue_random();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        while (letters_to_send.size() != 0 || s_valid) @(posedge aclk);
        while (cipher_letters_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d input beats: %0d enciphered and %0d deciphered pairs",
                 beats_in, enc_pairs, dec_pairs);
        $display("doubled-letter pairs %0d, padded final letters %0d, result beats %0d",
                 doubled_pairs, padded_pairs, beats_checked);
        if (fail_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

[playfair_digraph_cipher_top.f]
rtl/pfc_pkg.sv
rtl/pfc_ram.sv
rtl/pfc_front.sv
rtl/pfc_queue.sv
rtl/pfc_back.sv
rtl/playfair_digraph_cipher_top.sv
test/testbench.sv
